// ===== src/session_id_next_fit_allocator_assert.svh =====
// Assertion macros shared by the checkers of the session identifier allocator.
// No dependencies; the including file supplies clock, reset and expressions.
`ifndef SESSION_ID_NEXT_FIT_ALLOCATOR_ASSERT_SVH
`define SESSION_ID_NEXT_FIT_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIDAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define SIDAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/sidal_pkg.sv =====
// Shared types, constants and helper functions of the session identifier allocator.
// No dependencies; imported by the interfaces, the top level and the checker.
package sidal_pkg;

    localparam int POOL_SIZE = 256;
    localparam int WORD_W    = 16;
    localparam int NUM_WORDS = POOL_SIZE / WORD_W;
    localparam int ID_W      = 8;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int ROW_W     = $clog2(NUM_WORDS);
    localparam int GRANT_W   = 9;
    localparam int STATUS_W  = 2;

    localparam logic [GRANT_W-1:0] NO_ID = GRANT_W'(256);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_FREED     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } find_t;

    // Lowest clear bit of a bitmap word at or above the bit position lo.
    function automatic find_t find_free(input logic [WORD_W-1:0] word,
                                        input logic [BIT_W-1:0]  lo);
        find_t r;
        r = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!word[b] && (BIT_W'(b) >= lo)) begin
                r.found = 1'b1;
                r.idx   = BIT_W'(b);
            end
        end
        return r;
    endfunction

endpackage

// ===== src/sidal_if.sv =====
// Request and response channel interfaces of the session identifier allocator.
// Depends on sidal_pkg for the field widths.
interface sidal_req_if import sidal_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ID_W-1:0]   free_id;

    modport source (output valid, output req_type, output free_id, input ready);
    modport sink   (input valid, input req_type, input free_id, output ready);
endinterface

interface sidal_rsp_if import sidal_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [GRANT_W-1:0]  granted_id;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink   (input valid, input granted_id, input status, output ready);
endinterface

// ===== src/session_id_next_fit_allocator.sv =====
// Top level of the next-fit session identifier allocator.
// Depends on sidal_pkg and on the channel interfaces in sidal_if.sv.

// The allocator hands out identifiers 0..255 from a busy bitmap and takes them
// back. An allocate word advances the last-used pointer by one (wrapping after
// 255), then searches upward from it to 255 without wrapping and grants the
// first free identifier, which becomes the new pointer; when none is free it
// answers with status 1 and identifier 256 and keeps the advanced pointer. A
// free word clears the busy bit and answers with status 2 and identifier 256.
// Every request word produces exactly one response word. The bitmap lives in a
// 16 x 16-bit synchronous memory; a per-row valid flop makes a never-written
// row read as all free, so no clearing pass follows reset and requests are
// taken right away. One request is in flight at a time: a free passes through
// the scan and done states before the next request is accepted, and an allocate
// stays in the scan state for every 16-identifier row the search has to read,
// since the memory read port delivers one row per cycle. A finished response
// waits in an output register, so the next request is accepted while the
// previous response is still unclaimed; a request can only finish once that
// register has been emptied.
module session_id_next_fit_allocator
    import sidal_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sidal_req_if.sink  req,
    sidal_rsp_if.source rsp
);

    state_t state_reg, state_next;

    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [BIT_W-1:0]    lo_bit_reg, lo_bit_next;
    logic                kind_reg, kind_next;
    logic                in_pool_reg, in_pool_next;
    logic [ID_W-1:0]     last_reg, last_next;
    logic [GRANT_W-1:0]  res_id_reg, res_id_next;
    status_t             res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [GRANT_W-1:0]  out_id_reg, out_id_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [NUM_WORDS-1:0] row_valid_reg, row_valid_next;

    // Bitmap storage and its registered read port.
    logic [WORD_W-1:0] mem [NUM_WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en;
    logic [WORD_W-1:0] wr_word;

    logic              accept;
    logic              scan_done;
    logic [ID_W-1:0]   adv_ptr;
    logic [WORD_W-1:0] word_eff;
    find_t             fz;
    logic              out_free;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // The pointer moves one step forward before every search.
    assign adv_ptr = (last_reg == ID_W'(POOL_SIZE - 1)) ? '0 : last_reg + 1'b1;

    // A row that was never written holds no busy identifiers.
    assign word_eff = row_valid_reg[cur_row_reg] ? rd_data_reg : '0;
    assign fz       = find_free(word_eff, lo_bit_reg);

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[cur_row_reg] <= wr_word;
        end
        rd_data_reg <= mem[rd_row];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        req.ready       = 1'b0;
        rd_row          = cur_row_reg + 1'b1;
        wr_en           = 1'b0;
        wr_word         = word_eff;
        scan_done       = 1'b0;
        cur_row_next    = cur_row_reg;
        lo_bit_next     = lo_bit_reg;
        kind_next       = kind_reg;
        in_pool_next    = in_pool_reg;
        last_next       = last_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        row_valid_next  = row_valid_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE: begin
                req.ready = 1'b1;
                kind_next = req.req_type;
                if (req.req_type == REQ_FREE) begin
                    rd_row       = req.free_id[ID_W-1:BIT_W];
                    cur_row_next = req.free_id[ID_W-1:BIT_W];
                    lo_bit_next  = req.free_id[BIT_W-1:0];
                    in_pool_next = (GRANT_W'(req.free_id) < GRANT_W'(POOL_SIZE));
                end else begin
                    rd_row       = adv_ptr[ID_W-1:BIT_W];
                    cur_row_next = adv_ptr[ID_W-1:BIT_W];
                    lo_bit_next  = adv_ptr[BIT_W-1:0];
                    if (accept) begin
                        last_next = adv_ptr;
                    end
                end
            end
            S_SCAN: begin
                if (kind_reg == REQ_FREE) begin
                    scan_done       = 1'b1;
                    wr_en           = in_pool_reg;
                    wr_word         = word_eff & ~(WORD_W'(1) << lo_bit_reg);
                    res_id_next     = NO_ID;
                    res_status_next = ST_FREED;
                end else if (fz.found) begin
                    scan_done       = 1'b1;
                    wr_en           = 1'b1;
                    wr_word         = word_eff | (WORD_W'(1) << fz.idx);
                    last_next       = {cur_row_reg, fz.idx};
                    res_id_next     = GRANT_W'({cur_row_reg, fz.idx});
                    res_status_next = ST_GRANTED;
                end else if (cur_row_reg == ROW_W'(NUM_WORDS - 1)) begin
                    // Nothing free between the pointer and the top of the pool.
                    scan_done       = 1'b1;
                    res_id_next     = NO_ID;
                    res_status_next = ST_EXHAUSTED;
                end else begin
                    // The next row's read was issued this cycle.
                    cur_row_next = cur_row_reg + 1'b1;
                    lo_bit_next  = '0;
                end
                if (wr_en) begin
                    row_valid_next[cur_row_reg] = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_id_next     = res_id_reg;
                    out_status_next = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        cur_row_reg    <= cur_row_next;
        lo_bit_reg     <= lo_bit_next;
        kind_reg       <= kind_next;
        in_pool_reg    <= in_pool_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.granted_id = out_id_reg;
    assign rsp.status     = out_status_reg;

endmodule

// ===== src/sidal_checker.sv =====
// Port-level checker of the session identifier allocator, bound to the top level.
// Depends on sidal_pkg and on session_id_next_fit_allocator_assert.svh.
`include "session_id_next_fit_allocator_assert.svh"

module sidal_checker
    import sidal_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [GRANT_W-1:0]  rsp_granted_id,
    input logic [STATUS_W-1:0] rsp_status
);

    // Only a grant carries a real identifier; the others report the no-id code.
    `SIDAL_ASSERT_NOW(a_grant_id, clk, rst_n, rsp_valid && (rsp_status == ST_GRANTED), !rsp_granted_id[GRANT_W-1])
    `SIDAL_ASSERT_NOW(a_nogrant_id, clk, rst_n, rsp_valid && (rsp_status != ST_GRANTED), rsp_granted_id == NO_ID)

    // An accepted request is worked on before another one is taken.
    `SIDAL_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)

    // A waiting response keeps its content until it is taken.
    `SIDAL_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted_id) && $stable(rsp_status))

endmodule

bind session_id_next_fit_allocator sidal_checker u_sidal_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_granted_id (rsp.granted_id),
    .rsp_status     (rsp.status)
);
